// ===== design/hmed_pkg.sv =====
// Shared types and constants for the three-channel histogram median block.
// Used by hmed_lane and by the top level histogram_median_three_channel.
// No dependencies.
package hmed_pkg;

   // Sample width and number of histogram bins per channel.
   localparam int SAMPLE_W = 8;
   localparam int NUM_BINS = 256;
   localparam int NUM_LANES = 3;

   // Sequencer states of the top level.
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_LOAD,
      ST_DRAIN,
      ST_SCAN,
      ST_DONE,
      ST_PUSH
   } hmed_state_type;

   // Control bundle that the sequencer sends to every lane.
   typedef struct packed {
      logic                bin_en;     // count this item's sample
      logic                scan_en;    // read and zero the bin at scan_addr
      logic                scan_sum;   // accumulate the bins being read
      logic                scan_start; // restart the running sum
      logic [SAMPLE_W-1:0] scan_addr;
   } hmed_ctrl_type;

endpackage

// ===== design/histogram_median_three_channel.sv =====
// Top level of the three-channel histogram median: sequencer, pixel count,
// three histogram lanes and the result register that merges their medians.
// Depends on hmed_pkg and hmed_lane.
//
// Pixels are taken one per cycle while a window loads. The item with tlast
// closes the window: the block then stops taking items while it steps
// through ST_DRAIN (to let the last bin update land), ST_SCAN (in which the
// three lanes read and zero one bin each, in address order), ST_DONE
// (to finish the running sums) and ST_PUSH (to load the result register,
// which waits until any earlier result has been taken). After reset the
// block zeroes the bins in a clearing pass over every bin before it takes
// the first item. Pixels beyond MAX_PIXELS in a window are not counted and
// set the overflow flag of the result.
module histogram_median_three_channel #(
   parameter int MAX_PIXELS = 4096
) (
   input  logic        clock,
   input  logic        reset,
   // Pixel items.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // sample_ch0, sample_ch1, sample_ch2
   input  logic        req_tlast,  // last_pixel
   // Result items.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // median_ch0, median_ch1, median_ch2
   output logic        rsp_tuser   // count_overflow
);
   import hmed_pkg::*;

   localparam int CNT_W = $clog2(MAX_PIXELS + 1);

   hmed_state_type      state_ff;
   hmed_state_type      state_in;
   logic [SAMPLE_W-1:0] cnt_ff;
   logic [SAMPLE_W-1:0] cnt_in;
   logic [CNT_W-1:0]    total_ff;
   logic [CNT_W-1:0]    total_in;
   logic                ovf_ff;
   logic                ovf_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [23:0]         rsp_data_ff;
   logic                rsp_ovf_ff;
   logic                load_result;
   logic                req_accept;
   logic                total_full;
   logic [CNT_W-1:0]    half;
   hmed_ctrl_type       ctrl;
   logic [SAMPLE_W-1:0] median [NUM_LANES];

   assign req_accept = req_tvalid && req_tready;
   assign total_full = (total_ff == CNT_W'(MAX_PIXELS));
   assign half       = total_ff >> 1;

   // Sequencer: next state and lane control.
   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      total_in       = total_ff;
      ovf_in         = ovf_ff;
      req_tready     = 1'b0;
      load_result    = 1'b0;
      ctrl.bin_en    = 1'b0;
      ctrl.scan_en   = 1'b0;
      ctrl.scan_sum  = 1'b0;
      ctrl.scan_start = 1'b0;
      ctrl.scan_addr = cnt_ff;
      case (state_ff)
         ST_CLEAR: begin
            ctrl.scan_en = 1'b1;
            cnt_in = cnt_ff + SAMPLE_W'(1);
            if (cnt_ff == '1) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            req_tready = 1'b1;
            if (req_accept) begin
               if (total_full) begin
                  ovf_in = 1'b1;
               end else begin
                  ctrl.bin_en = 1'b1;
                  total_in = total_ff + CNT_W'(1);
               end
               if (req_tlast) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            ctrl.scan_start = 1'b1;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            ctrl.scan_en  = 1'b1;
            ctrl.scan_sum = 1'b1;
            cnt_in = cnt_ff + SAMPLE_W'(1);
            if (cnt_ff == '1) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            state_in = ST_PUSH;
         end
         ST_PUSH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               load_result = 1'b1;
               total_in = '0;
               ovf_in   = 1'b0;
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_CLEAR;
            cnt_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cnt_ff   <= '0;
         total_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         total_ff <= total_in;
         ovf_ff   <= ovf_in;
      end
   end

   // Histogram lanes, one per channel.
   for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
      hmed_lane #(
         .CNT_W(CNT_W)
      ) u_lane (
         .clock (clock),
         .reset (reset),
         .ctrl  (ctrl),
         .sample(req_tdata[g*SAMPLE_W +: SAMPLE_W]),
         .half  (half),
         .median(median[g])
      );
   end

   // Result register: merges the three lane medians with the overflow flag.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (load_result) begin
         rsp_data_ff <= {median[2], median[1], median[0]};
         rsp_ovf_ff  <= ovf_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_ovf_ff;

   // The pixel count never passes the window limit.
   a_total_limit: assert property (@(posedge clock) disable iff (reset)
      total_ff <= CNT_W'(MAX_PIXELS))
      else $error("pixel count above limit");

   // Overflow is only flagged once the window is full.
   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> total_full)
      else $error("overflow flagged below the limit");

   // A closing item always starts the drain and scan.
   a_last_drain: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_tlast |=> state_ff == ST_DRAIN)
      else $error("closing item did not start the scan");

   // The scan walks the bins in order.
   a_scan_step: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN && cnt_ff != '1 |=>
         state_ff == ST_SCAN && cnt_ff == $past(cnt_ff) + SAMPLE_W'(1))
      else $error("scan address skipped");

endmodule

// ===== design/hmed_lane.sv =====
// One histogram lane: a 256-bin counter memory with read-modify-write
// binning and a cumulative scan that finds the median and zeroes the bins.
// Depends on hmed_pkg.
module hmed_lane #(
   parameter int CNT_W = 13
) (
   input  logic                         clock,
   input  logic                         reset,
   input  hmed_pkg::hmed_ctrl_type      ctrl,
   input  logic [hmed_pkg::SAMPLE_W-1:0] sample,
   input  logic [CNT_W-1:0]             half,
   output logic [hmed_pkg::SAMPLE_W-1:0] median
);
   import hmed_pkg::*;

   // Bin counter memory.
   logic [CNT_W-1:0]    bins_mem [NUM_BINS];

   logic [SAMPLE_W-1:0] rd_addr;
   logic [CNT_W-1:0]    rd_ff;

   // Binning pipeline: the address of the item read in the previous cycle.
   logic                bin_v_ff;
   logic [SAMPLE_W-1:0] bin_addr_ff;

   // Last write, kept to forward it to an item that read the same bin
   // before the write landed.
   logic                wr_v_ff;
   logic [SAMPLE_W-1:0] wr_addr_ff;
   logic [CNT_W-1:0]    wr_data_ff;
   logic [CNT_W-1:0]    bin_cur;
   logic [CNT_W-1:0]    bin_new;

   // Scan pipeline.
   logic                sv_ff;
   logic [SAMPLE_W-1:0] sa_ff;
   logic [CNT_W-1:0]    acc_ff;
   logic [CNT_W-1:0]    acc_in;
   logic                found_ff;
   logic                found_in;
   logic [SAMPLE_W-1:0] median_ff;
   logic [SAMPLE_W-1:0] median_in;

   assign rd_addr = ctrl.scan_en ? ctrl.scan_addr : sample;

   // Forward the previous write when it hit the bin now being updated.
   assign bin_cur = (wr_v_ff && (wr_addr_ff == bin_addr_ff)) ? wr_data_ff : rd_ff;
   assign bin_new = bin_cur + CNT_W'(1);

   // Memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (bin_v_ff) begin
         bins_mem[bin_addr_ff] <= bin_new;
      end else if (ctrl.scan_en) begin
         bins_mem[ctrl.scan_addr] <= '0;
      end
      rd_ff <= bins_mem[rd_addr];
   end

   // Binning and forwarding registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         bin_v_ff <= 1'b0;
         wr_v_ff  <= 1'b0;
      end else begin
         bin_v_ff <= ctrl.bin_en;
         wr_v_ff  <= bin_v_ff;
      end
      bin_addr_ff <= sample;
      wr_addr_ff  <= bin_addr_ff;
      wr_data_ff  <= bin_new;
   end

   // Running cumulative sum; the first bin whose sum exceeds half wins.
   always_comb begin
      acc_in    = acc_ff;
      found_in  = found_ff;
      median_in = median_ff;
      if (ctrl.scan_start) begin
         acc_in    = '0;
         found_in  = 1'b0;
         median_in = '0;
      end else if (sv_ff) begin
         acc_in = acc_ff + rd_ff;
         if (!found_ff && (acc_in > half)) begin
            found_in  = 1'b1;
            median_in = sa_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sv_ff     <= 1'b0;
         found_ff  <= 1'b0;
         acc_ff    <= '0;
         median_ff <= '0;
      end else begin
         sv_ff     <= ctrl.scan_en && ctrl.scan_sum;
         found_ff  <= found_in;
         acc_ff    <= acc_in;
         median_ff <= median_in;
      end
      sa_ff <= ctrl.scan_addr;
   end

   assign median = median_ff;

   // A found median is never replaced later in the same scan.
   a_found_holds: assert property (@(posedge clock) disable iff (reset)
      found_ff && !ctrl.scan_start |=> found_ff && $stable(median_ff))
      else $error("median changed after it was found");

   // Binning and scanning never overlap.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(bin_v_ff && ctrl.scan_en))
      else $error("bin update collided with scan");

   // The running sum never falls during a scan.
   a_acc_monotonic: assert property (@(posedge clock) disable iff (reset)
      sv_ff && !ctrl.scan_start |=> acc_ff >= $past(acc_ff))
      else $error("cumulative sum decreased");

endmodule
